/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the ASCII formatting core.
// No dependencies; take in by `include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ITOA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ITOA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* design/itoa_pkg.sv */
// Types, codes and the digit table of the ASCII formatting core.
// No dependencies; imported by every module of the core.
package itoa_pkg;

   localparam int VALUE_W = 64;
   localparam int DIGITS  = 20;
   localparam int BCD_W   = 4 * DIGITS;
   localparam int CNT_W   = 5;
   localparam int STEP_W  = 6;
   localparam int CHAR_W  = 7;

   localparam logic [1:0] FUNC_UDEC  = 2'd0;
   localparam logic [1:0] FUNC_SDEC  = 2'd1;
   localparam logic [1:0] FUNC_HEX   = 2'd2;
   localparam logic [1:0] FUNC_HEX0X = 2'd3;

   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_X     = 7'h78;

   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_MINUS,
      PRE_HEX
   } prefix_type;

   typedef struct packed {
      logic [BCD_W-1:0] digits;
      prefix_type       prefix;
   } emit_cmd_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      case (d)
         4'h0: c = 7'h30;
         4'h1: c = 7'h31;
         4'h2: c = 7'h32;
         4'h3: c = 7'h33;
         4'h4: c = 7'h34;
         4'h5: c = 7'h35;
         4'h6: c = 7'h36;
         4'h7: c = 7'h37;
         4'h8: c = 7'h38;
         4'h9: c = 7'h39;
         4'ha: c = 7'h61;
         4'hb: c = 7'h62;
         4'hc: c = 7'h63;
         4'hd: c = 7'h64;
         4'he: c = 7'h65;
         default: c = 7'h66;
      endcase
      return c;
   endfunction

endpackage

/* design/itoa_dabble.sv */
// Bit-serial binary to BCD converter (double dabble), one input bit a cycle.
// Depends on itoa_pkg.
module itoa_dabble import itoa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] mag,
   output logic               done,
   output logic [BCD_W-1:0]   bcd
);

   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in, adj;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = mag;
         bcd_in   = '0;
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {adj[BCD_W-2:0], shift_ff[VALUE_W-1]};
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(VALUE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

/* design/itoa_emit.sv */
// Character emitter: prefix, leading-zero drop and one digit per word out.
// Depends on itoa_pkg.
module itoa_emit import itoa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  emit_cmd_type      cmd,
   output logic              idle,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_ascii_char,
   output logic              rsp_last
);

   typedef enum logic [2:0] {
      E_IDLE,
      E_PRE,
      E_X,
      E_SKIP,
      E_DIG
   } state_type;

   state_type         state_ff, state_in;
   logic [BCD_W-1:0]  dig_ff, dig_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   prefix_type        prefix_ff, prefix_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic [3:0]        top;
   logic              adv;

   assign top = dig_ff[BCD_W-1 -: 4];
   assign adv = !valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      cnt_in    = cnt_ff;
      prefix_in = prefix_ff;
      valid_in  = valid_ff && rsp_stall;
      char_in   = char_ff;
      last_in   = last_ff;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               dig_in    = cmd.digits;
               cnt_in    = CNT_W'(DIGITS);
               prefix_in = cmd.prefix;
               state_in  = (cmd.prefix == PRE_NONE) ? E_SKIP : E_PRE;
            end
         end
         E_PRE: begin
            if (adv) begin
               valid_in = 1'b1;
               char_in  = (prefix_ff == PRE_MINUS) ? CH_MINUS : CH_ZERO;
               last_in  = 1'b0;
               state_in = (prefix_ff == PRE_HEX) ? E_X : E_SKIP;
            end
         end
         E_X: begin
            if (adv) begin
               valid_in = 1'b1;
               char_in  = CH_X;
               last_in  = 1'b0;
               state_in = E_SKIP;
            end
         end
         E_SKIP: begin
            // drop leading zeros, but keep the final digit
            if (top == 4'd0 && cnt_ff != CNT_W'(1)) begin
               dig_in = {dig_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               state_in = E_DIG;
            end
         end
         E_DIG: begin
            if (adv) begin
               valid_in = 1'b1;
               char_in  = digit_char(top);
               last_in  = (cnt_ff == CNT_W'(1));
               dig_in   = {dig_ff[BCD_W-5:0], 4'd0};
               cnt_in   = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = E_IDLE;
               end
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      dig_ff    <= dig_in;
      cnt_ff    <= cnt_in;
      prefix_ff <= prefix_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign idle           = (state_ff == E_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

/* design/int_to_ascii_dec_hex_core.sv */
// Top level of the 64-bit word to ASCII text formatter.
// Depends on itoa_pkg, itoa_dabble, itoa_emit and assert_macros.svh.
//
// One request word (func, value) turns into 1 to 20 response words, one ASCII
// character each, most significant first, with rsp_last on the final one.
// A decimal request runs through the bit-serial double dabble register, which
// then hands its digits to the emitter. The emitter walks all 20 digit
// positions whatever the value: it drops the leading zeros, then sends one
// character per remaining digit; a '-' goes out ahead of the digits. Hex skips
// the conversion and walks the same 20 positions, the top four always zero;
// the '0x' prefix goes out ahead of the digits. No new request is taken until
// the emitter has registered the final character and gone idle. While
// rsp_stall holds back a waiting character, the rest of the text waits too.
// The final character may still wait in the output register when the next
// request is taken.
module int_to_ascii_dec_hex_core import itoa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_ascii_char,
   output logic               rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic               neg_ff, neg_in;
   logic               accept, is_hex, is_neg;
   logic               dab_done, emit_start, emit_idle;
   logic [BCD_W-1:0]   dab_bcd;
   logic [VALUE_W-1:0] mag;
   emit_cmd_type       emit_cmd;

   assign accept = req_valid && !req_stall;
   assign is_hex = (req_func == FUNC_HEX) || (req_func == FUNC_HEX0X);
   assign is_neg = (req_func == FUNC_SDEC) && req_value[VALUE_W-1];
   assign mag    = is_neg ? (VALUE_W'(0) - req_value) : req_value;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      emit_start      = 1'b0;
      emit_cmd.digits = dab_bcd;
      emit_cmd.prefix = neg_ff ? PRE_MINUS : PRE_NONE;
      state_in        = state_ff;
      neg_in          = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = is_neg;
               if (is_hex) begin
                  // hex needs no conversion: nibbles go straight out
                  emit_start      = 1'b1;
                  emit_cmd.digits = {{(BCD_W - VALUE_W){1'b0}}, req_value};
                  emit_cmd.prefix = (req_func == FUNC_HEX0X) ? PRE_HEX : PRE_NONE;
                  state_in        = ST_EMIT;
               end else begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            if (dab_done) begin
               emit_start = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_idle) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   itoa_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (accept && !is_hex),
      .mag   (mag),
      .done  (dab_done),
      .bcd   (dab_bcd)
   );

   itoa_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .start          (emit_start),
      .cmd            (emit_cmd),
      .idle           (emit_idle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   `include "assert_macros.svh"

   `ITOA_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `ITOA_ASSERT_IMP(a_emit_start_idle, clock, reset, emit_start, emit_idle)
   `ITOA_ASSERT_IMP(a_done_in_conv, clock, reset, dab_done, state_ff == ST_CONV)

endmodule

/* tb/sv/int_to_ascii_dec_hex_core_tb.sv */
// Self-checking testbench for int_to_ascii_dec_hex_core: predicts the ASCII text
// of every accepted request word and checks each response word against it.
// Depends on itoa_pkg and the RTL of the formatting core.
module int_to_ascii_dec_hex_core_tb import itoa_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int    CYCLE_LIMIT  = 500000;
   localparam int    RANDOM_WORDS = 118;
   localparam int    DRAIN_CYCLES = 150;
   localparam string HEX_GLYPHS   = "0123456789abcdef";

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_UDEC;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAR_W-1:0]  rsp_ascii_char;
   logic               rsp_last;

   char_word_type pending_chars[$];
   char_word_type want_char;
   int            fail_count = 0;
   int            cycle_count = 0;
   int            burst_left = 0;

   // Receiver pacing: the test bumps hold_asks to request a long hold-off.
   int hold_asks = 0;
   int hold_len = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_mode_left = 0;

   int_to_ascii_dec_hex_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("int_to_ascii_dec_hex_core_tb: FAIL");
         $finish;
      end
   end

   // Work out the text of one word and queue its characters.
   task automatic format_word(input logic [1:0] func, input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0]  txt[$];
      logic [CHAR_W-1:0]  digs[$];
      logic [3:0]         nib;
      bit                 seen;
      char_word_type      cw;
      seen = 0;
      if (func == FUNC_UDEC || func == FUNC_SDEC) begin
         mag = value;
         if (func == FUNC_SDEC && value[VALUE_W-1]) begin
            txt.push_back(CH_MINUS);
            mag = 64'd0 - value;
         end
         do begin
            digs.push_front(CH_ZERO + CHAR_W'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         foreach (digs[i]) txt.push_back(digs[i]);
      end else begin
         if (func == FUNC_HEX0X) begin
            txt.push_back(CH_ZERO);
            txt.push_back(CH_X);
         end
         for (int i = 15; i >= 0; i--) begin
            nib = value[i*4 +: 4];
            if (seen || nib != 0 || i == 0) begin
               txt.push_back(CHAR_W'(HEX_GLYPHS[nib]));
               seen = 1;
            end
         end
      end
      foreach (txt[k]) begin
         cw.ch   = txt[k];
         cw.last = (k == txt.size() - 1);
         pending_chars.push_back(cw);
      end
   endtask

   // Finish a burst with a random gap, else keep valid high for the next word.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 9) == 0) gap = $urandom_range(40, 130);
         else gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [1:0] func, input logic [VALUE_W-1:0] value);
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      format_word(func, value);
      pace_sender();
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(20, 200);
         end
         stall_mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected rsp word: char %h last %b", rsp_ascii_char, rsp_last);
            fail_count++;
         end else begin
            want_char = pending_chars.pop_front();
            if (rsp_ascii_char !== want_char.ch) begin
               $error("rsp_ascii_char: expected %h, got %h", want_char.ch, rsp_ascii_char);
               fail_count++;
            end
            if (rsp_last !== want_char.last) begin
               $error("rsp_last: expected %b, got %b", want_char.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Extremes of each mode, the most negative value and zero in every form.
   task automatic test_directed();
      send_word(FUNC_UDEC, 64'd0);
      send_word(FUNC_UDEC, 64'd9);
      send_word(FUNC_UDEC, 64'd10);
      send_word(FUNC_UDEC, 64'd9999999999999999999);
      send_word(FUNC_UDEC, 64'd10000000000000000000);
      send_word(FUNC_UDEC, 64'hffff_ffff_ffff_ffff);
      send_word(FUNC_SDEC, 64'd0);
      send_word(FUNC_SDEC, 64'd1);
      send_word(FUNC_SDEC, 64'hffff_ffff_ffff_ffff);
      send_word(FUNC_SDEC, 64'h8000_0000_0000_0000);
      send_word(FUNC_SDEC, 64'h7fff_ffff_ffff_ffff);
      send_word(FUNC_SDEC, 64'hffff_ffff_ffff_fff6);
      send_word(FUNC_HEX, 64'h0);
      send_word(FUNC_HEX, 64'hf);
      send_word(FUNC_HEX, 64'h10);
      send_word(FUNC_HEX, 64'h0123_4567_89ab_cdef);
      send_word(FUNC_HEX, 64'hffff_ffff_ffff_ffff);
      send_word(FUNC_HEX, 64'h8000_0000_0000_0000);
      send_word(FUNC_HEX0X, 64'h0);
      send_word(FUNC_HEX0X, 64'h1);
      send_word(FUNC_HEX0X, 64'ha5);
      send_word(FUNC_HEX0X, 64'hfedc_ba98_7654_3210);
   endtask

   // Hold rsp off for a long stretch while words keep coming back to back.
   task automatic test_backpressure();
      hold_len   = 600;
      hold_asks++;
      burst_left = 12;
      for (int i = 0; i < 10; i++)
         send_word(2'($urandom_range(0, 3)), {$urandom, $urandom});
   endtask

   task automatic test_random();
      logic [VALUE_W-1:0] value;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         case ($urandom_range(0, 3))
            0: value = {$urandom, $urandom};
            1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: value = 64'($urandom_range(0, 20));
            default: value = 64'd0 - ({$urandom, $urandom} >> $urandom_range(1, 63));
         endcase
         send_word(2'($urandom_range(0, 3)), value);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $error("%0d characters never arrived", pending_chars.size());
         fail_count++;
      end
      if (fail_count == 0) $display("int_to_ascii_dec_hex_core_tb: PASS");
      else $display("int_to_ascii_dec_hex_core_tb: FAIL");
      $finish;
   end

endmodule
